// File: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, pipeline depth and fixed-point constants shared by the normal unit.
// ----------------------------------------------------------------------------
package tun_pkg;

   // Field and datapath widths
   localparam int CoordW   = 32;    // Q16.16 corner coordinate
   localparam int EdgeW    = 33;    // exact edge difference
   localparam int ProdW    = 66;    // signed 33x33 product, also cross component
   localparam int MagW     = 65;    // cross component magnitude
   localparam int LoW      = 32;    // low limb of the magnitude
   localparam int HiW      = MagW - LoW;
   localparam int SqW      = 130;   // squared cross component
   localparam int SumW     = 132;   // squared length of the cross product
   localparam int RemW     = 200;   // root search remainder and running product
   localparam int QuotW    = 31;    // unit magnitude, up to 2^30
   localparam int OutW     = 32;    // Q2.30 result component

   // Pipeline layout: seven front stages, one per result bit, one output stage
   localparam int NumFront  = 7;
   localparam int NumIter   = QuotW;
   localparam int NumStages = NumFront + NumIter + 1;

   // Scale of c^2 in the rounding test: (2q-1)^2 * S <= c^2 * 2^62
   localparam int ScaleShift = 62;
   localparam logic [OutW-1:0] OneQ30 = 32'h4000_0000;

   typedef logic signed [EdgeW-1:0] edge_type;
   typedef logic signed [ProdW-1:0] prod_type;
   typedef logic [MagW-1:0]         mag_type;
   typedef logic [SqW-1:0]          sq_type;
   typedef logic [SumW-1:0]         sum_type;
   typedef logic signed [RemW-1:0]  rem_type;
   typedef logic [QuotW-1:0]        quot_type;

endpackage

// File: sv/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Forms both edges from corner 0, their exact cross product and scales it
// to unit length in Q2.30, rounded to nearest with ties away from zero. A zero
// cross product gives the fallback normal (0,0,1) with the degenerate flag.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | req_v{0,1,2}_{x,y,z}, Q16.16
//  rsp     | out       | rsp_valid / rsp_ready | rsp_normal_{x,y,z} Q2.30,
//          |           |                       | rsp_degenerate
//
//  One request enters per cycle while the output is not stalled; each result
//  passes seven stages for edges, cross product, squares and setup, one stage
//  per result bit of the exact root search, and the output register. Reset
//  clears all stage valid bits. A result waiting on rsp_ready holds the whole
//  pipeline in place; nothing is dropped or repeated.
//
module triangle_unit_normal (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [tun_pkg::CoordW-1:0] req_v0_x,
   input  logic signed [tun_pkg::CoordW-1:0] req_v0_y,
   input  logic signed [tun_pkg::CoordW-1:0] req_v0_z,
   input  logic signed [tun_pkg::CoordW-1:0] req_v1_x,
   input  logic signed [tun_pkg::CoordW-1:0] req_v1_y,
   input  logic signed [tun_pkg::CoordW-1:0] req_v1_z,
   input  logic signed [tun_pkg::CoordW-1:0] req_v2_x,
   input  logic signed [tun_pkg::CoordW-1:0] req_v2_y,
   input  logic signed [tun_pkg::CoordW-1:0] req_v2_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [tun_pkg::OutW-1:0]   rsp_normal_x,
   output logic signed [tun_pkg::OutW-1:0]   rsp_normal_y,
   output logic signed [tun_pkg::OutW-1:0]   rsp_normal_z,
   output logic                            rsp_degenerate
);
   import tun_pkg::*;

   // Pipeline control
   logic                 adv;
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;

   // Front stages
   logic signed [CoordW-1:0] v0 [3];
   logic signed [CoordW-1:0] v1 [3];
   logic signed [CoordW-1:0] v2 [3];
   edge_type e0_ff [3];
   edge_type e1_ff [3];
   prod_type pa_ff [3];
   prod_type pb_ff [3];
   prod_type cr    [3];
   mag_type  mag_ff [3];
   logic     neg3_ff [3];
   logic     deg3_ff;
   logic [2*HiW-1:0]   hh_ff [3];
   logic [HiW+LoW-1:0] hl_ff [3];
   logic [2*LoW-1:0]   ll_ff [3];
   logic     neg4_ff [3];
   logic     deg4_ff;
   sq_type   csq5_ff [3];
   logic     neg5_ff [3];
   logic     deg5_ff;
   sq_type   csq6_ff [3];
   sum_type  s6_ff;
   logic     neg6_ff [3];
   logic     deg6_ff;

   // Root search stages, index 0 is the setup stage output
   rem_type  it_r_ff [NumIter+1][3];
   rem_type  it_p_ff [NumIter+1][3];
   quot_type it_q_ff [NumIter+1][3];
   logic     it_neg_ff [NumIter+1][3];
   sum_type  it_s_ff [NumIter+1];
   logic     it_deg_ff [NumIter+1];

   // Hold every stage while a finished result waits
   assign adv       = !(vld_ff[NumStages-1] && !rsp_ready);
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NumStages-1];

   assign vld_in = {vld_ff[NumStages-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign v0[0] = req_v0_x;  assign v0[1] = req_v0_y;  assign v0[2] = req_v0_z;
   assign v1[0] = req_v1_x;  assign v1[1] = req_v1_y;  assign v1[2] = req_v1_z;
   assign v2[0] = req_v2_x;  assign v2[1] = req_v2_y;  assign v2[2] = req_v2_z;

   // Cross components from registered products
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cr[l] = pa_ff[l] - pb_ff[l];
      end
   end

   // Edges, cross product, magnitudes, squares, sum of squares
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            e0_ff[l] <= EdgeW'(v1[l]) - EdgeW'(v0[l]);
            e1_ff[l] <= EdgeW'(v2[l]) - EdgeW'(v0[l]);
         end
         pa_ff[0] <= e0_ff[1] * e1_ff[2];
         pb_ff[0] <= e0_ff[2] * e1_ff[1];
         pa_ff[1] <= e0_ff[2] * e1_ff[0];
         pb_ff[1] <= e0_ff[0] * e1_ff[2];
         pa_ff[2] <= e0_ff[0] * e1_ff[1];
         pb_ff[2] <= e0_ff[1] * e1_ff[0];
         for (int l = 0; l < 3; l++) begin
            neg3_ff[l] <= cr[l][ProdW-1];
            mag_ff[l]  <= cr[l][ProdW-1] ? MagW'(-cr[l]) : MagW'(cr[l]);
         end
         deg3_ff <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
         for (int l = 0; l < 3; l++) begin
            hh_ff[l]   <= mag_ff[l][MagW-1:LoW] * mag_ff[l][MagW-1:LoW];
            hl_ff[l]   <= mag_ff[l][MagW-1:LoW] * mag_ff[l][LoW-1:0];
            ll_ff[l]   <= mag_ff[l][LoW-1:0] * mag_ff[l][LoW-1:0];
            neg4_ff[l] <= neg3_ff[l];
         end
         deg4_ff <= deg3_ff;
         for (int l = 0; l < 3; l++) begin
            csq5_ff[l] <= (SqW'(hh_ff[l]) << (2*LoW)) + (SqW'(hl_ff[l]) << (LoW+1))
                          + SqW'(ll_ff[l]);
            neg5_ff[l] <= neg4_ff[l];
         end
         deg5_ff <= deg4_ff;
         s6_ff   <= SumW'(csq5_ff[0]) + SumW'(csq5_ff[1]) + SumW'(csq5_ff[2]);
         for (int l = 0; l < 3; l++) begin
            csq6_ff[l] <= csq5_ff[l];
            neg6_ff[l] <= neg5_ff[l];
         end
         deg6_ff <= deg5_ff;
      end
   end

   // Set up the search at q = 0: remainder c^2*2^62 - S, product -S
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            it_r_ff[0][l]   <= (RemW'(csq6_ff[l]) << ScaleShift) - RemW'(s6_ff);
            it_p_ff[0][l]   <= -RemW'(s6_ff);
            it_q_ff[0][l]   <= '0;
            it_neg_ff[0][l] <= neg6_ff[l];
         end
         it_s_ff[0]   <= s6_ff;
         it_deg_ff[0] <= deg6_ff;
      end
   end

   // One result bit per stage, most significant first
   for (genvar j = 0; j < NumIter; j++) begin : g_iter
      localparam int K = NumIter - 1 - j;
      rem_type trial [3];

      // Try adding 2^K to q: remainder drops by 2d*P + d^2*S with d = 2^(K+1)
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            trial[l] = it_r_ff[j][l] - (it_p_ff[j][l] <<< (K+2))
                       - (RemW'(it_s_ff[j]) << (2*K+2));
         end
      end

      // Keep the bit when the remainder stays non-negative
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               if (!trial[l][RemW-1]) begin
                  it_r_ff[j+1][l] <= trial[l];
                  it_p_ff[j+1][l] <= it_p_ff[j][l] + (RemW'(it_s_ff[j]) << (K+1));
                  it_q_ff[j+1][l] <= it_q_ff[j][l] | (QuotW'(1) << K);
               end else begin
                  it_r_ff[j+1][l] <= it_r_ff[j][l];
                  it_p_ff[j+1][l] <= it_p_ff[j][l];
                  it_q_ff[j+1][l] <= it_q_ff[j][l];
               end
               it_neg_ff[j+1][l] <= it_neg_ff[j][l];
            end
            it_s_ff[j+1]   <= it_s_ff[j];
            it_deg_ff[j+1] <= it_deg_ff[j];
         end
      end
   end

   // Apply signs, or give the fallback normal
   always_ff @(posedge clock) begin
      if (adv) begin
         if (it_deg_ff[NumIter]) begin
            rsp_normal_x <= '0;
            rsp_normal_y <= '0;
            rsp_normal_z <= OneQ30;
         end else begin
            rsp_normal_x <= it_neg_ff[NumIter][0] ? -OutW'(it_q_ff[NumIter][0])
                                                   : OutW'(it_q_ff[NumIter][0]);
            rsp_normal_y <= it_neg_ff[NumIter][1] ? -OutW'(it_q_ff[NumIter][1])
                                                   : OutW'(it_q_ff[NumIter][1]);
            rsp_normal_z <= it_neg_ff[NumIter][2] ? -OutW'(it_q_ff[NumIter][2])
                                                   : OutW'(it_q_ff[NumIter][2]);
         end
         rsp_degenerate <= it_deg_ff[NumIter];
      end
   end

   // Fallback normal comes with the degenerate flag
   a_deg_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == OneQ30)
      else $error("degenerate result without fallback normal");

   // A real normal is never the zero vector
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("zero normal on a non-degenerate triangle");

   // Root search never passes one; a zero-area search is discarded
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NumStages-2] && !it_deg_ff[NumIter] |->
         it_q_ff[NumIter][0] <= QuotW'(OneQ30) && it_q_ff[NumIter][1] <= QuotW'(OneQ30)
         && it_q_ff[NumIter][2] <= QuotW'(OneQ30))
      else $error("unit magnitude above one");

   // A held result stays in place
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff[NumStages-1] && $stable(rsp_normal_x) && $stable(rsp_degenerate))
      else $error("pipeline moved during a stall");

endmodule

// File: tb/triangle_unit_normal_test.sv
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles through the normal unit under several idle and stall
// patterns. It predicts each exact unit normal with wide integer arithmetic
// and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal_test;
   import tun_pkg::*;

   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 60;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct {
      coord_type v[9];
   } tri_type;

   typedef struct {
      logic signed [OutW-1:0] nx;
      logic signed [OutW-1:0] ny;
      logic signed [OutW-1:0] nz;
      logic                   degen;
   } normal_type;

   // Expected normals in arrival order and the exact predictor
   class normal_board;
      normal_type pending[$];
      int         errors;

      function new();
         errors = 0;
      endfunction

      // Largest q in [0, 2^30] with (2q-1)^2 * s <= m^2 * 2^62
      function automatic logic [31:0] unit_mag(logic [255:0] m, logic [255:0] s);
         logic [255:0] lim;
         logic [255:0] d;
         longint lo;
         longint hi;
         longint mid;
         lim = (m * m) << ScaleShift;
         lo = 0;
         hi = 64'h4000_0000;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            d = 256'(2 * mid - 1);
            if (d * d * s <= lim) lo = mid;
            else hi = mid - 1;
         end
         return 32'(lo);
      endfunction

      function automatic normal_type face_normal(tri_type t);
         logic signed [33:0] ea[3];
         logic signed [33:0] eb[3];
         logic signed [69:0] c[3];
         logic [255:0]       m[3];
         logic [255:0]       s;
         logic [31:0]        q[3];
         normal_type         r;
         for (int i = 0; i < 3; i++) begin
            ea[i] = t.v[3 + i] - t.v[i];
            eb[i] = t.v[6 + i] - t.v[i];
         end
         c[0] = ea[1] * eb[2] - ea[2] * eb[1];
         c[1] = ea[2] * eb[0] - ea[0] * eb[2];
         c[2] = ea[0] * eb[1] - ea[1] * eb[0];
         if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r.nx = '0;
            r.ny = '0;
            r.nz = OneQ30;
            r.degen = 1'b1;
            return r;
         end
         s = '0;
         for (int i = 0; i < 3; i++) begin
            m[i] = 256'(c[i] < 0 ? -c[i] : c[i]);
            s += m[i] * m[i];
         end
         for (int i = 0; i < 3; i++) begin
            q[i] = unit_mag(m[i], s);
            if (c[i] < 0) q[i] = -q[i];
         end
         r.nx = q[0];
         r.ny = q[1];
         r.nz = q[2];
         r.degen = 1'b0;
         return r;
      endfunction

      function void note_request(tri_type t);
         pending.push_back(face_normal(t));
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(normal_type got);
         normal_type want;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.nx !== want.nx) report("normal_x", got.nx, want.nx);
         if (got.ny !== want.ny) report("normal_y", got.ny, want.ny);
         if (got.nz !== want.nz) report("normal_z", got.nz, want.nz);
         if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
      endtask
   endclass

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_ready;
   coord_type req_v0_x = '0, req_v0_y = '0, req_v0_z = '0;
   coord_type req_v1_x = '0, req_v1_y = '0, req_v1_z = '0;
   coord_type req_v2_x = '0, req_v2_y = '0, req_v2_z = '0;
   logic   rsp_valid;
   logic   rsp_ready = 1'b0;
   logic signed [OutW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic   rsp_degenerate;

   normal_board board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   triangle_unit_normal uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_v0_x(req_v0_x), .req_v0_y(req_v0_y), .req_v0_z(req_v0_z),
      .req_v1_x(req_v1_x), .req_v1_y(req_v1_y), .req_v1_z(req_v1_z),
      .req_v2_x(req_v2_x), .req_v2_y(req_v2_y), .req_v2_z(req_v2_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Note accepted requests, check accepted results, pick next ready
   always @(posedge clock) begin
      tri_type    t;
      normal_type r;
      if (!reset && req_valid && req_ready) begin
         t.v = '{req_v0_x, req_v0_y, req_v0_z, req_v1_x, req_v1_y, req_v1_z,
                 req_v2_x, req_v2_y, req_v2_z};
         board.note_request(t);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         r.nx = rsp_normal_x;
         r.ny = rsp_normal_y;
         r.nz = rsp_normal_z;
         r.degen = rsp_degenerate;
         board.check_result(r);
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (req_valid || board.pending.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Drive one request, idling first at random, hold until accepted
   task automatic send_tri(tri_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_v0_x, req_v0_y, req_v0_z} <= {t.v[0], t.v[1], t.v[2]};
      {req_v1_x, req_v1_y, req_v1_z} <= {t.v[3], t.v[4], t.v[5]};
      {req_v2_x, req_v2_y, req_v2_z} <= {t.v[6], t.v[7], t.v[8]};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(2000)) - 1000;
         2: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
         default: return ($urandom_range(1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      endcase
   endfunction

   // Random triangle: mostly general, some with shared corners or collinear
   function automatic tri_type rand_tri();
      tri_type t;
      int   mode;
      int   k;
      mode = $urandom_range(3);
      for (int i = 0; i < 9; i++) begin
         t.v[i] = ($urandom_range(9) == 0) ? rand_coord(3) : rand_coord(mode);
      end
      case ($urandom_range(9))
         0: for (int i = 0; i < 3; i++) t.v[3 + i] = t.v[i];
         1: for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[3 + i];
         2: begin
            k = $signed($urandom_range(6)) - 3;
            for (int i = 0; i < 3; i++) begin
               t.v[i] = rand_coord(1);
               t.v[3 + i] = t.v[i] + rand_coord(1);
               t.v[6 + i] = t.v[i] + k * (t.v[3 + i] - t.v[i]);
            end
         end
         default: ;
      endcase
      return t;
   endfunction

   function automatic tri_type mk(coord_type a0, coord_type a1, coord_type a2,
                                  coord_type b0, coord_type b1, coord_type b2,
                                  coord_type c0, coord_type c1, coord_type c2);
      tri_type t;
      t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
      return t;
   endfunction

   localparam coord_type Mx  = 32'sh7fff_ffff;
   localparam coord_type Mn  = 32'sh8000_0000;
   localparam coord_type One = 32'sh0001_0000;

   initial begin
      tri_type directed[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: axis faces, degenerate shapes, full-range corners
      directed.push_back(mk(0, 0, 0, One, 0, 0, 0, One, 0));
      directed.push_back(mk(0, 0, 0, 0, One, 0, One, 0, 0));
      directed.push_back(mk(0, 0, 0, 0, One, 0, 0, 0, One));
      directed.push_back(mk(0, 0, 0, 0, 0, One, 0, One, 0));
      directed.push_back(mk(0, 0, 0, 0, 0, One, One, 0, 0));
      directed.push_back(mk(0, 0, 0, One, 0, 0, 0, 0, One));
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(5, 6, 7, 5, 6, 7, 9, 1, 2));
      directed.push_back(mk(5, 6, 7, 9, 1, 2, 9, 1, 2));
      directed.push_back(mk(0, 0, 0, 1, 2, 3, 2, 4, 6));
      directed.push_back(mk(1, 1, 1, 2, 2, 2, -5, -5, -5));
      directed.push_back(mk(Mn, Mn, Mn, Mx, Mn, Mn, Mn, Mx, Mn));
      directed.push_back(mk(Mx, Mx, Mx, Mn, Mx, Mx, Mx, Mn, Mx));
      directed.push_back(mk(Mn, Mn, Mn, Mx, Mx, Mn, Mn, Mx, Mx));
      directed.push_back(mk(Mx, Mn, Mx, Mn, Mx, Mn, Mx, Mx, Mn));
      directed.push_back(mk(Mn, Mn, Mn, Mx, Mx, Mx, Mn, Mn, Mn));
      directed.push_back(mk(0, 0, 0, 1, 1, 0, 1, 0, 1));
      directed.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 1));
      directed.push_back(mk(-1, -1, -1, 0, 0, 0, 3, -7, 2));
      directed.push_back(mk(0, 0, 0, 1, 0, 0, 1, 1, 0));
      directed.push_back(mk(Mx, 0, 0, Mn, 0, 0, 0, 1, 0));
      foreach (directed[i]) send_tri(directed[i]);
      drain();

      // Random phases over the idle and stall patterns
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (int n = 0; n < 283; n++) begin
            if (n == 140 && ph == 2) drain();
            send_tri(rand_tri());
         end
      end
      drain();
      repeat (DrainCycles) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
